>>> rtl/core/lpf_pkg.sv
`default_nettype none

package lpf_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [WORD_W-1:0] FRAME_MAGIC_RESET     = 32'd0;
    localparam logic [WORD_W-1:0] MAX_PAYLOAD_LEN_RESET = 32'd65536;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA      = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_TOO_LONG  = 2'd3
    } kind_t;

    typedef enum logic {
        OP_PUSH    = 1'b0,
        OP_DISCARD = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_MAGIC     = 1'b0,
        CFG_MAX_PAYLOAD_LEN = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] frame_magic;
        logic [WORD_W-1:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [WORD_W-1:0] msg_type;
        logic [WORD_W-1:0] msg_id;
        logic [WORD_W-1:0] payload_length;
        logic              first_byte;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/lpf_if.sv
`default_nettype none

interface lpf_in_if
    import lpf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface lpf_out_if
    import lpf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [WORD_W-1:0] msg_type;
    logic [WORD_W-1:0] msg_id;
    logic [WORD_W-1:0] payload_length;
    logic              first_byte;
    logic              last;

    modport source (
        output valid, output kind, output payload_byte, output msg_type,
        output msg_id, output payload_length, output first_byte,
        output last, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input msg_type,
        input msg_id, input payload_length, input first_byte,
        input last, output ready
    );
endinterface

interface lpf_cfg_if
    import lpf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lpf_cfg_regs.sv
`default_nettype none

module lpf_cfg_regs
    import lpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpf_cfg_if.sink    cfg,
    output cfg_t       cfg_out
);

    logic [WORD_W-1:0] frame_magic_reg;
    logic [WORD_W-1:0] max_len_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_magic_reg <= FRAME_MAGIC_RESET;
            max_len_reg     <= MAX_PAYLOAD_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_FRAME_MAGIC:     frame_magic_reg <= cfg.data;
                CFG_MAX_PAYLOAD_LEN: max_len_reg     <= cfg.data;
                default:             ;
            endcase
        end
    end

    assign cfg_out.frame_magic     = frame_magic_reg;
    assign cfg_out.max_payload_len = max_len_reg;

endmodule

`default_nettype wire

>>> rtl/core/lpf_in_stage.sv
`default_nettype none

module lpf_in_stage
    import lpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpf_in_if.sink     rx,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;
    logic  take;

    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op        <= op_t'(rx.op);
            item_reg.data_byte <= rx.data_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> rtl/core/lpf_core.sv
`default_nettype none

module lpf_core
    import lpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output logic       advance,
    lpf_out_if.source  tx
);

    phase_t                phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [WORD_W-1:0]     magic_reg, magic_next;
    logic [WORD_W-1:0]     length_reg, length_next;
    logic [WORD_W-1:0]     type_reg, type_next;
    logic [WORD_W-1:0]     id_reg, id_next;
    logic [WORD_W-1:0]     left_reg, left_next;
    logic                  out_valid_reg;
    result_t               res_reg, res_next;
    logic                  res_emit;
    logic [4:0]            lane_sh;

    assign advance  = item_valid && (!out_valid_reg || tx.ready);
    assign lane_sh  = {hdr_cnt_reg[1:0], 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= '0;
            magic_reg   <= '0;
            length_reg  <= '0;
            type_reg    <= '0;
            id_reg      <= '0;
            left_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            magic_reg   <= magic_next;
            length_reg  <= length_next;
            type_reg    <= type_next;
            id_reg      <= id_next;
            left_reg    <= left_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        magic_next   = magic_reg;
        length_next  = length_reg;
        type_next    = type_reg;
        id_next      = id_reg;
        left_next    = left_reg;
        res_emit     = 1'b0;
        res_next.kind         = KIND_DATA;
        res_next.payload_byte = '0;
        res_next.first_byte   = 1'b1;
        res_next.last         = 1'b1;

        if (item.op == OP_DISCARD)
        begin
            phase_next   = PH_HEADER;
            hdr_cnt_next = '0;
            magic_next   = '0;
            length_next  = '0;
            type_next    = '0;
            id_next      = '0;
            left_next    = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HALTED:
                begin
                    // bytes dropped until discard
                end
                PH_PAYLOAD:
                begin
                    res_emit              = 1'b1;
                    res_next.kind         = KIND_DATA;
                    res_next.payload_byte = item.data_byte;
                    res_next.first_byte   = (left_reg == length_reg);
                    res_next.last         = (left_reg <= 32'd1);
                    if (left_reg <= 32'd1)
                    begin
                        left_next    = '0;
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = '0;
                    end
                    else
                    begin
                        left_next = left_reg - 32'd1;
                    end
                end
                default:
                begin
                    // header collection, also the unused phase code
                    phase_next = PH_HEADER;
                    case (hdr_cnt_reg[3:2])
                        2'd0:    magic_next[lane_sh +: BYTE_W]  = item.data_byte;
                        2'd1:    length_next[lane_sh +: BYTE_W] = item.data_byte;
                        2'd2:    type_next[lane_sh +: BYTE_W]   = item.data_byte;
                        default: id_next[lane_sh +: BYTE_W]     = item.data_byte;
                    endcase
                    hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
                    if (hdr_cnt_reg == HDR_CNT_W'(HEADER_BYTES - 1))
                    begin
                        // magic and length words are already complete here
                        hdr_cnt_next = '0;
                        if (magic_reg != cfg.frame_magic)
                        begin
                            res_emit      = 1'b1;
                            res_next.kind = KIND_BAD_MAGIC;
                            phase_next    = PH_HALTED;
                        end
                        else if (length_reg > cfg.max_payload_len)
                        begin
                            res_emit      = 1'b1;
                            res_next.kind = KIND_TOO_LONG;
                            phase_next    = PH_HALTED;
                        end
                        else if (length_reg == '0)
                        begin
                            res_emit      = 1'b1;
                            res_next.kind = KIND_EMPTY;
                        end
                        else
                        begin
                            left_next  = length_reg;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end

        res_next.msg_type       = type_next;
        res_next.msg_id         = id_next;
        res_next.payload_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_emit;
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_emit)
        begin
            res_reg <= res_next;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.kind           = res_reg.kind;
    assign tx.payload_byte   = res_reg.payload_byte;
    assign tx.msg_type       = res_reg.msg_type;
    assign tx.msg_id         = res_reg.msg_id;
    assign tx.payload_length = res_reg.payload_length;
    assign tx.first_byte     = res_reg.first_byte;
    assign tx.last           = res_reg.last;

`ifndef SYNTHESIS
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != '0 && left_reg <= length_reg)
        else $error("payload count out of range");

    a_discard_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.op == OP_DISCARD |=> phase_reg == PH_HEADER && hdr_cnt_reg == '0)
        else $error("discard did not clear frame state");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.op == OP_PUSH && phase_reg == PH_HALTED |=> !out_valid_reg)
        else $error("result while halted");

    a_error_marks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.kind != KIND_DATA |-> res_reg.first_byte && res_reg.last)
        else $error("non-data result not marked first and last");
`endif

endmodule

`default_nettype wire

>>> rtl/core/length_prefixed_frame_parser_unit.sv
// length-prefixed frame parser
// rx carries one transaction per stream byte (op push) or a discard (op discard).
// each frame is a 16-byte little-endian header (magic, length, type, id)
// followed by length payload bytes; tx gives one transaction per payload byte,
// tagged with the header words and first/last marks.
// a zero length gives one empty-frame transaction; a bad magic or a length over
// max_payload_len gives one error transaction, after which pushed bytes are
// dropped until a discard arrives. header bytes and discards give no output.
// cfg writes frame_magic (index 0) and max_payload_len (index 1); write only
// while the block is idle. cfg is always ready.
// throughput: one rx transaction per cycle while tx does not stall, set by the
// single state-update stage between the input register and the output register.
// a pushed byte's result goes from rx through the input register and then the
// output register onto tx.
// when tx stalls, the output register holds its result and the input register
// takes one more byte, then rx.ready drops until tx drains.
// reset clears the handshake state, the header state and loads the register
// defaults (magic 0, max length 65536); no other warm-up is needed.
`default_nettype none

module length_prefixed_frame_parser_unit
    import lpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpf_in_if.sink     rx,
    lpf_out_if.source  tx,
    lpf_cfg_if.sink    cfg
);

    cfg_t  cfg_words;
    item_t item;
    logic  item_valid;
    logic  advance;

    lpf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_words)
    );

    lpf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lpf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_words),
        .advance    (advance),
        .tx         (tx)
    );

endmodule

`default_nettype wire

>>> bench/length_prefixed_frame_parser_unit_tb.sv
`timescale 1ns / 1ps

module length_prefixed_frame_parser_unit_tb;
    import lpf_pkg::*;

    class frame_tracker;
        logic [WORD_W-1:0] frame_magic;
        logic [WORD_W-1:0] max_len;
        phase_t            ph;
        logic [4:0]        hdr_cnt;
        logic [WORD_W-1:0] magic_w;
        logic [WORD_W-1:0] len_w;
        logic [WORD_W-1:0] type_w;
        logic [WORD_W-1:0] id_w;
        logic [WORD_W-1:0] bytes_left;
        result_t           pending_results[$];
        int                mismatches;

        function new();
            frame_magic = FRAME_MAGIC_RESET;
            max_len     = MAX_PAYLOAD_LEN_RESET;
            mismatches  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            ph         = PH_HEADER;
            hdr_cnt    = '0;
            magic_w    = '0;
            len_w      = '0;
            type_w     = '0;
            id_w       = '0;
            bytes_left = '0;
        endfunction

        function void set_config(cfg_idx_t idx, logic [WORD_W-1:0] value);
            if (idx == CFG_FRAME_MAGIC)
                frame_magic = value;
            else
                max_len = value;
        endfunction

        function void queue_result(kind_t k, logic [BYTE_W-1:0] b, logic f, logic l);
            result_t r;
            r.kind           = k;
            r.payload_byte   = b;
            r.msg_type       = type_w;
            r.msg_id         = id_w;
            r.payload_length = len_w;
            r.first_byte     = f;
            r.last           = l;
            pending_results.push_back(r);
        endfunction

        // advance the deframer state by one accepted transaction
        function void note_item(op_t op, logic [BYTE_W-1:0] b);
            int sh;
            if (op == OP_DISCARD)
            begin
                clear_frame();
                return;
            end
            if (ph == PH_HALTED)
                return;
            if (ph == PH_PAYLOAD)
            begin
                queue_result(KIND_DATA, b, bytes_left == len_w, bytes_left <= 1);
                if (bytes_left > 0)
                    bytes_left = bytes_left - 1;
                if (bytes_left == 0)
                begin
                    ph      = PH_HEADER;
                    hdr_cnt = '0;
                end
                return;
            end
            ph = PH_HEADER;
            sh = 8 * hdr_cnt[1:0];
            case (hdr_cnt[3:2])
                2'd0: magic_w[sh +: 8] = b;
                2'd1: len_w[sh +: 8]   = b;
                2'd2: type_w[sh +: 8]  = b;
                default: id_w[sh +: 8] = b;
            endcase
            hdr_cnt = hdr_cnt + 5'd1;
            if (hdr_cnt < HEADER_BYTES)
                return;
            hdr_cnt = '0;
            if (magic_w != frame_magic)
            begin
                queue_result(KIND_BAD_MAGIC, '0, 1'b1, 1'b1);
                ph = PH_HALTED;
            end
            else if (len_w > max_len)
            begin
                queue_result(KIND_TOO_LONG, '0, 1'b1, 1'b1);
                ph = PH_HALTED;
            end
            else if (len_w == 0)
                queue_result(KIND_EMPTY, '0, 1'b1, 1'b1);
            else
            begin
                bytes_left = len_w;
                ph         = PH_PAYLOAD;
            end
        endfunction

        function void cmp_field(string fname, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s expected %h got %h", $time, fname, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result expected none got kind %0d byte %h",
                         $time, got.kind, got.payload_byte);
                return;
            end
            want = pending_results.pop_front();
            cmp_field("kind", want.kind, got.kind);
            cmp_field("payload_byte", want.payload_byte, got.payload_byte);
            cmp_field("msg_type", want.msg_type, got.msg_type);
            cmp_field("msg_id", want.msg_id, got.msg_id);
            cmp_field("payload_length", want.payload_length, got.payload_length);
            cmp_field("first_byte", want.first_byte, got.first_byte);
            cmp_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lpf_in_if  rx_if ();
    lpf_out_if tx_if ();
    lpf_cfg_if cfg_if ();

    length_prefixed_frame_parser_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if),
        .cfg   (cfg_if)
    );

    frame_tracker tracker = new();

    int                src_idle;
    int                snk_idle;
    bit                hold_req;
    int                hold_left;
    int                items_sent;
    logic [WORD_W-1:0] cur_magic;
    logic [WORD_W-1:0] cur_max;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: check accepted transactions, then choose next ready
    initial
    begin
        result_t got;
        tx_if.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (tx_if.valid === 1'b1 && tx_if.ready === 1'b1)
            begin
                got.kind           = kind_t'(tx_if.kind);
                got.payload_byte   = tx_if.payload_byte;
                got.msg_type       = tx_if.msg_type;
                got.msg_id         = tx_if.msg_id;
                got.payload_length = tx_if.payload_length;
                got.first_byte     = tx_if.first_byte;
                got.last           = tx_if.last;
                tracker.check_result(got);
            end
            if (hold_req)
            begin
                hold_left = 64;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end
            else
                tx_if.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL length_prefixed_frame_parser_unit");
        $finish;
    end

    task automatic send_item(op_t op, logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.op        <= op;
        rx_if.data_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        tracker.note_item(op, b);
        items_sent++;
    endtask

    task automatic push_byte(logic [BYTE_W-1:0] b);
        send_item(OP_PUSH, b);
    endtask

    task automatic discard();
        send_item(OP_DISCARD, $urandom_range(255));
    endtask

    task automatic send_word(logic [WORD_W-1:0] w);
        for (int k = 0; k < 4; k++)
            push_byte(w[8*k +: 8]);
    endtask

    task automatic send_header(logic [WORD_W-1:0] m, logic [WORD_W-1:0] l,
                               logic [WORD_W-1:0] t, logic [WORD_W-1:0] i);
        send_word(m);
        send_word(l);
        send_word(t);
        send_word(i);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        // header bytes and discards give no result but may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        tracker.set_config(idx, value);
        if (idx == CFG_FRAME_MAGIC)
            cur_magic = value;
        else
            cur_max = value;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] wrong_magic();
        logic [WORD_W-1:0] m;
        if ($urandom_range(1))
            m = cur_magic ^ (32'h1 << $urandom_range(31));
        else
            m = $urandom;
        if (m == cur_magic)
            m = ~cur_magic;
        return m;
    endfunction

    task automatic good_frame(logic [WORD_W-1:0] len);
        send_header(cur_magic, len, pick_word(), pick_word());
        for (int k = 0; k < len; k++)
            push_byte($urandom_range(255));
    endtask

    task automatic halt_and_discard();
        repeat ($urandom_range(3)) push_byte($urandom_range(255));
        discard();
    endtask

    task automatic random_frame();
        int                sel;
        int                cut;
        logic [WORD_W-1:0] len;
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            if (cur_max == 0)
                len = 0;
            else
                len = $urandom_range(cur_max > 12 ? 12 : cur_max, 1);
            if ($urandom_range(19) == 0 && len > 1)
            begin
                // abandon the frame part way through its payload
                cut = $urandom_range(len - 1, 1);
                send_header(cur_magic, len, pick_word(), pick_word());
                repeat (cut) push_byte($urandom_range(255));
                discard();
            end
            else
                good_frame(len);
        end
        else if (sel < 56 && cur_max >= 1000)
        begin
            // long frame: check the tags on a few bytes, then drop it
            len = ($urandom_range(1) && cur_max == '1) ? '1 : $urandom_range(cur_max, 1000);
            send_header(cur_magic, len, pick_word(), pick_word());
            repeat ($urandom_range(5, 1)) push_byte($urandom_range(255));
            discard();
        end
        else if (sel < 64)
            send_header(cur_magic, '0, pick_word(), pick_word());
        else if (sel < 74 || (sel < 84 && cur_max == '1))
        begin
            send_header(wrong_magic(), pick_word(), pick_word(), pick_word());
            halt_and_discard();
        end
        else if (sel < 84)
        begin
            len = $urandom_range(1) ? cur_max + 1 : $urandom_range(32'hFFFF_FFFF, cur_max + 1);
            send_header(cur_magic, len, pick_word(), pick_word());
            halt_and_discard();
        end
        else if (sel < 92)
        begin
            repeat ($urandom_range(15, 1)) push_byte($urandom_range(255));
            discard();
        end
        else
        begin
            repeat ($urandom_range(4, 1)) send_item(op_t'($urandom_range(1)), $urandom_range(255));
            discard();
        end
    endtask

    task automatic random_frames(int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
            random_frame();
        discard();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        rx_if.valid     <= 1'b0;
        rx_if.op        <= OP_PUSH;
        rx_if.data_byte <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_FRAME_MAGIC;
        cfg_if.data     <= '0;
        hold_req        = 1'b0;
        items_sent      = 0;
        cur_magic       = FRAME_MAGIC_RESET;
        cur_max         = MAX_PAYLOAD_LEN_RESET;
        src_idle        = 31;
        snk_idle        = 77;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: partial header, empty frame, short frame, both errors
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        discard();
        send_header(cur_magic, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_header(cur_magic, 32'd2, 32'd0, 32'hFFFF_FFFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        send_header(32'd1, 32'd0, 32'h1234_5678, 32'h9ABC_DEF0);
        push_byte(8'hAB);
        discard();
        send_header(cur_magic, MAX_PAYLOAD_LEN_RESET + 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        discard();

        random_frames(150);

        write_reg(CFG_FRAME_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_PAYLOAD_LEN, 32'd0);
        random_frames(150);

        src_idle = 77;
        snk_idle = 31;
        write_reg(CFG_FRAME_MAGIC, $urandom);
        write_reg(CFG_MAX_PAYLOAD_LEN, 32'd20);
        random_frames(200);

        write_reg(CFG_FRAME_MAGIC, 32'd0);
        write_reg(CFG_MAX_PAYLOAD_LEN, 32'hFFFF_FFFF);
        random_frames(150);

        src_idle = 0;
        snk_idle = 0;
        write_reg(CFG_FRAME_MAGIC, $urandom);
        write_reg(CFG_MAX_PAYLOAD_LEN, 32'd6);
        // long receiver hold-off while payload keeps coming
        hold_req = 1'b1;
        repeat (3) good_frame(cur_max);
        random_frames(200);

        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS length_prefixed_frame_parser_unit");
        else
            $display("FAIL length_prefixed_frame_parser_unit");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lpf_pkg.sv
rtl/core/lpf_if.sv
rtl/core/lpf_cfg_regs.sv
rtl/core/lpf_in_stage.sv
rtl/core/lpf_core.sv
rtl/core/length_prefixed_frame_parser_unit.sv
bench/length_prefixed_frame_parser_unit_tb.sv
